/* rtl/slt_pkg.sv */
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants for the sorted list table: table depth, key and
// count widths, command and status codes, and the structs that run along the
// cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

	localparam int DEPTH     = 64;
	localparam int KEY_WIDTH = 32;
	localparam int CNT_W     = $clog2(DEPTH + 1);

	// command codes
	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_DELETE = 3'd1,
		CMD_LOOKUP = 3'd2,
		CMD_RESET  = 3'd3,
		CMD_NEXT   = 3'd4,
		CMD_CLEAR  = 3'd5
	} command_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_MISSING  = 2'd2,
		ST_PAST_END = 2'd3
	} status_t;

	// broadcast to every cell
	typedef struct packed {
		logic                 ins;
		logic                 del;
		logic                 clr;
		logic [KEY_WIDTH-1:0] key;
	} cell_ctrl_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic                 valid;
		logic                 lt;
		logic [KEY_WIDTH-1:0] key;
	} cell_link_t;

endpackage

`default_nettype wire

/* rtl/slt_if.sv */
// ----------------------------------------------------------------------------
// slt_if
// Valid/ready channels of the sorted list table: the command word going in
// and the result word coming out.
// ----------------------------------------------------------------------------
`default_nettype none

interface slt_req_if import slt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [2:0]           command;
	logic [KEY_WIDTH-1:0] key;

	modport source (output valid, output command, output key, input ready);
	modport sink   (input valid, input command, input key, output ready);
endinterface

interface slt_rsp_if import slt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [KEY_WIDTH-1:0] value;
	logic                 found;
	logic [1:0]           status;
	logic [CNT_W-1:0]     count;
	logic                 full_res;

	modport source (output valid, output value, output found, output status,
		output count, output full_res, input ready);
	modport sink   (input valid, input value, input found, input status,
		input count, input full_res, output ready);
endinterface

`default_nettype wire

/* rtl/slt_cell.sv */
// ----------------------------------------------------------------------------
// slt_cell
// One slot of the sorted table. Holds a key and a valid bit, compares its
// key with the broadcast key, and takes the new key or its lower neighbor's
// entry when an insert shifts the table, or its upper neighbor's on a delete.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_cell import slt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire cell_link_t lo_nb,
	input  wire cell_link_t hi_nb,
	output cell_link_t      link,
	output logic            hit
);

	logic                 valid_q;
	logic [KEY_WIDTH-1:0] key_q;

	// compare against the broadcast key
	assign link.valid = valid_q;
	assign link.key   = key_q;
	assign link.lt    = valid_q && (key_q < ctrl.key);

	// first equal entry: lower neighbor is smaller, or this is the bottom slot
	assign hit = valid_q && (key_q == ctrl.key) && lo_nb.lt;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clr) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins) begin
			valid_q <= valid_q | lo_nb.valid;
		end else if (ctrl.del && !link.lt) begin
			valid_q <= hi_nb.valid;
		end
	end

	// key storage, shifts up on insert and down on delete
	always_ff @(posedge clk) begin
		if (ctrl.ins && !link.lt) begin
			key_q <= lo_nb.lt ? ctrl.key : lo_nb.key;
		end else if (ctrl.del && !link.lt) begin
			key_q <= hi_nb.key;
		end
	end

endmodule

`default_nettype wire

/* rtl/sorted_list_table_top.sv */
// ----------------------------------------------------------------------------
// sorted_list_table_top
// Sorted key table built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// The table takes one command word per clock cycle and returns one result
// word for each, registered in the cycle after the command is accepted. Every
// cell compares its key with the incoming key in the same cycle, so insert,
// delete and lookup all finish as they are accepted, whatever the table size;
// the result register decouples the two sides, and a new command is taken
// whenever that register is empty or being drained. There is no clearing
// pass after reset: the table is empty and ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_table_top import slt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	slt_req_if.sink   req,
	slt_rsp_if.source rsp
);

	cell_ctrl_t       ctrl;
	cell_link_t       links [DEPTH];
	logic [DEPTH-1:0] hits;
	logic [DEPTH-1:0] valids;
	logic [KEY_WIDTH-1:0] rd_terms [DEPTH];

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cursor_q;

	logic                 rsp_valid_q;
	logic [KEY_WIDTH-1:0] value_q;
	logic                 found_q;
	status_t              status_q;
	logic [CNT_W-1:0]     rsp_count_q;
	logic                 full_q;

	logic                 accept;
	logic                 full;
	logic                 found_any;
	logic                 rd_ok;
	logic [KEY_WIDTH-1:0] rd_value;
	command_t             cmd;

	logic [KEY_WIDTH-1:0] value_d;
	logic                 found_d;
	status_t              status_d;
	logic [CNT_W-1:0]     count_d;
	logic [CNT_W-1:0]     cursor_d;

	// handshake
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign cmd       = command_t'(req.command);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign found_any = |hits;

	// broadcast control
	assign ctrl.key = req.key;
	assign ctrl.ins = accept && (cmd == CMD_INSERT) && !full;
	assign ctrl.del = accept && (cmd == CMD_DELETE) && found_any;
	assign ctrl.clr = accept && (cmd == CMD_CLEAR);

	// cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_link_t lo_nb;
		cell_link_t hi_nb;

		if (i == 0) begin : g_bottom
			assign lo_nb = '{valid: 1'b1, lt: 1'b1, key: '0};
		end else begin : g_lo
			assign lo_nb = links[i-1];
		end

		if (i == DEPTH - 1) begin : g_top
			assign hi_nb = '{valid: 1'b0, lt: 1'b0, key: '0};
		end else begin : g_hi
			assign hi_nb = links[i+1];
		end

		slt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.lo_nb  (lo_nb),
			.hi_nb  (hi_nb),
			.link   (links[i]),
			.hit    (hits[i])
		);

		assign valids[i]   = links[i].valid;
		assign rd_terms[i] = (cursor_q == CNT_W'(i)) ? links[i].key : '0;
	end

	// entry under the cursor
	always_comb begin
		rd_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_value = rd_value | rd_terms[i];
		end
	end

	assign rd_ok = (cursor_q < count_q);

	// result and next counters
	always_comb begin
		value_d  = '0;
		found_d  = 1'b0;
		status_d = ST_OK;
		count_d  = count_q;
		cursor_d = cursor_q;
		unique case (cmd)
			CMD_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				if (found_any) begin
					found_d = 1'b1;
					count_d = count_q - CNT_W'(1);
				end else begin
					status_d = ST_MISSING;
				end
			end
			CMD_LOOKUP: begin
				if (found_any) begin
					found_d = 1'b1;
					value_d = req.key;
				end else begin
					status_d = ST_MISSING;
				end
			end
			CMD_RESET: begin
				cursor_d = '0;
			end
			CMD_NEXT: begin
				if (rd_ok) begin
					value_d  = rd_value;
					cursor_d = cursor_q + CNT_W'(1);
				end else begin
					status_d = ST_PAST_END;
				end
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	// table counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
		end else if (accept) begin
			count_q  <= count_d;
			cursor_q <= cursor_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q     <= value_d;
			found_q     <= found_d;
			status_q    <= status_d;
			rsp_count_q <= count_d;
			full_q      <= (count_d == CNT_W'(DEPTH));
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.value    = value_q;
	assign rsp.found    = found_q;
	assign rsp.status   = status_q;
	assign rsp.count    = rsp_count_q;
	assign rsp.full_res = full_q;

	// occupied cells always match the count
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valids) == int'(count_q))
		else $error("cell occupancy disagrees with count");

	// count stays within the table
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("count beyond table depth");

	// sorted order gives at most one first-equal cell
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hits))
		else $error("more than one matching cell");

	// an insert into a full table leaves the count alone
	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd == CMD_INSERT) && full) |=> $stable(count_q))
		else $error("insert into full table changed count");

endmodule

`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted list table.
// ----------------------------------------------------------------------------
// Command words go in on the request channel and each one is mirrored into a
// behavioral copy of the table, which works out the result word it should
// return. Result words from the block are matched in order against those
// predictions field by field. The run covers a short set of corner cases,
// a fill to capacity with a full walk of the entries, and random traffic in
// phases with different sender idle and receiver stall rates.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import slt_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// spare command codes, decoded as no-ops
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_WORDS  = 360;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic [KEY_WIDTH-1:0] value;
		logic                 found;
		logic [1:0]           status;
		logic [CNT_W-1:0]     count;
		logic                 full_res;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n;

	slt_req_if req_ch ();
	slt_rsp_if rsp_ch ();

	sorted_list_table_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// mirror of the table contents
	logic [KEY_WIDTH-1:0] keys_held [DEPTH];
	int unsigned          held_count;
	int unsigned          read_ptr;

	table_result_t        pending_results [$];
	logic [KEY_WIDTH-1:0] key_pool [8];
	int                   err_cnt;
	int                   cycle_cnt;
	int                   idle_pct;
	int                   stall_pct;

	always #10 clk = ~clk;

	// run time guard
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// apply one command word to the mirror and return the expected result
	function automatic table_result_t apply_command(input logic [2:0] cmd,
		input logic [KEY_WIDTH-1:0] k);
		table_result_t res;
		int unsigned   pos;
		res = '0;
		res.status = ST_OK;
		pos = 0;
		if (cmd == CMD_INSERT || cmd == CMD_DELETE || cmd == CMD_LOOKUP) begin
			while (pos < held_count && keys_held[pos] < k)
				pos++;
		end
		case (cmd)
			CMD_INSERT: begin
				if (held_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (int i = held_count; i > pos; i--)
						keys_held[i] = keys_held[i-1];
					keys_held[pos] = k;
					held_count++;
				end
			end
			CMD_DELETE: begin
				if (pos < held_count && keys_held[pos] == k) begin
					for (int i = pos + 1; i < held_count; i++)
						keys_held[i-1] = keys_held[i];
					held_count--;
					res.found = 1'b1;
				end else begin
					res.status = ST_MISSING;
				end
			end
			CMD_LOOKUP: begin
				if (pos < held_count && keys_held[pos] == k) begin
					res.value = keys_held[pos];
					res.found = 1'b1;
				end else begin
					res.status = ST_MISSING;
				end
			end
			CMD_RESET: begin
				read_ptr = 0;
			end
			CMD_NEXT: begin
				if (read_ptr < held_count) begin
					res.value = keys_held[read_ptr];
					read_ptr++;
				end else begin
					res.status = ST_PAST_END;
				end
			end
			CMD_CLEAR: begin
				held_count = 0;
			end
			default: begin
			end
		endcase
		res.count    = CNT_W'(held_count);
		res.full_res = (held_count == DEPTH);
		return res;
	endfunction

	task automatic note_error(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endtask

	// compare one result word against the oldest prediction
	task automatic check_result();
		table_result_t got;
		table_result_t want;
		got = {rsp_ch.value, rsp_ch.found, rsp_ch.status, rsp_ch.count, rsp_ch.full_res};
		if (pending_results.size() == 0) begin
			note_error($sformatf("result word with nothing pending: %h", got));
		end else begin
			want = pending_results.pop_front();
			if (got.value !== want.value)
				note_error($sformatf("value: expected %h got %h", want.value, got.value));
			if (got.found !== want.found)
				note_error($sformatf("found: expected %b got %b", want.found, got.found));
			if (got.status !== want.status)
				note_error($sformatf("status: expected %0d got %0d", want.status, got.status));
			if (got.count !== want.count)
				note_error($sformatf("count: expected %0d got %0d", want.count, got.count));
			if (got.full_res !== want.full_res)
				note_error($sformatf("full_res: expected %b got %b", want.full_res,
					got.full_res));
		end
	endtask

	// result checking and prediction on accepted words
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				check_result();
			if (req_ch.valid && req_ch.ready)
				pending_results.push_back(apply_command(req_ch.command, req_ch.key));
		end
	end

	// send one command word, with random idle cycles ahead of it
	task automatic send_word(input logic [2:0] cmd, input logic [KEY_WIDTH-1:0] k);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			req_ch.key   <= $urandom();
			@(negedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.command <= cmd;
		req_ch.key     <= k;
		do
			@(posedge clk);
		while (!(req_ch.valid && req_ch.ready));
	endtask

	// hold off the sender until every pending result has come back
	task automatic wait_for_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// key from the table, from a pool of corner and random values, or fully random
	function automatic logic [KEY_WIDTH-1:0] pick_key(input bit from_table);
		if (from_table && held_count > 0 && $urandom_range(99) < 60)
			return keys_held[$urandom_range(held_count - 1)];
		if ($urandom_range(1) == 0)
			return key_pool[$urandom_range(7)];
		return $urandom();
	endfunction

	task automatic test_corner_cases();
		idle_pct  = 0;
		stall_pct = 0;
		// empty table
		send_word(CMD_NEXT,   32'h0);
		send_word(CMD_LOOKUP, 32'h0);
		send_word(CMD_DELETE, 32'h0);
		// extremes and a duplicate
		send_word(CMD_INSERT, 32'hFFFF_FFFF);
		send_word(CMD_INSERT, 32'h0);
		send_word(CMD_INSERT, 32'h0);
		send_word(CMD_INSERT, 32'h8000_0000);
		send_word(CMD_LOOKUP, 32'hFFFF_FFFF);
		send_word(CMD_LOOKUP, 32'h0);
		send_word(CMD_LOOKUP, 32'h1);
		send_word(CMD_DELETE, 32'h0001_2345);
		// spare codes leave everything alone
		send_word(CMD_SPARE6, 32'hFFFF_FFFF);
		send_word(CMD_SPARE7, 32'h0);
		// walk the entries and run off the end
		send_word(CMD_RESET,  32'h5555_5555);
		repeat (5)
			send_word(CMD_NEXT, 32'hAAAA_AAAA);
		// cursor is kept across delete, insert and clear
		send_word(CMD_DELETE, 32'h0);
		send_word(CMD_INSERT, 32'h7);
		send_word(CMD_NEXT,   32'h0);
		send_word(CMD_CLEAR,  32'hFFFF_FFFF);
		send_word(CMD_NEXT,   32'h0);
		send_word(CMD_RESET,  32'h0);
		wait_for_results();
	endtask

	task automatic test_fill_and_walk();
		logic [KEY_WIDTH-1:0] last_key;
		logic [KEY_WIDTH-1:0] k;
		idle_pct  = 14;
		stall_pct = 14;
		last_key  = '0;
		send_word(CMD_CLEAR, $urandom());
		// fill to capacity with extremes and runs of duplicates
		for (int i = 0; i < DEPTH; i++) begin
			if (i == 0)
				k = 32'h0;
			else if (i == 1)
				k = 32'hFFFF_FFFF;
			else if (i % 3 == 2)
				k = last_key;
			else
				k = $urandom();
			last_key = k;
			send_word(CMD_INSERT, k);
		end
		send_word(CMD_INSERT, 32'h0);
		send_word(CMD_INSERT, $urandom());
		wait_for_results();
		send_word(CMD_LOOKUP, keys_held[0]);
		send_word(CMD_LOOKUP, keys_held[DEPTH-1]);
		send_word(CMD_DELETE, $urandom());
		wait_for_results();
		// walk every entry, then one past the end
		send_word(CMD_RESET, $urandom());
		repeat (DEPTH + 1)
			send_word(CMD_NEXT, $urandom());
		wait_for_results();
		send_word(CMD_DELETE, keys_held[5]);
		send_word(CMD_INSERT, 32'h1);
		send_word(CMD_INSERT, 32'h2);
		send_word(CMD_CLEAR,  $urandom());
		send_word(CMD_NEXT,   $urandom());
		send_word(CMD_LOOKUP, 32'h0);
		wait_for_results();
	endtask

	task automatic run_random_phase(input int sender_idle, input int receiver_stall);
		int unsigned          pick;
		logic [2:0]           cmd;
		logic [KEY_WIDTH-1:0] k;
		idle_pct  = sender_idle;
		stall_pct = receiver_stall;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(399);
			if (pick < 140)
				cmd = CMD_INSERT;
			else if (pick < 220)
				cmd = CMD_DELETE;
			else if (pick < 290)
				cmd = CMD_LOOKUP;
			else if (pick < 310)
				cmd = CMD_RESET;
			else if (pick < 380)
				cmd = CMD_NEXT;
			else if (pick < 382)
				cmd = CMD_CLEAR;
			else if (pick < 391)
				cmd = CMD_SPARE6;
			else
				cmd = CMD_SPARE7;
			if (cmd == CMD_INSERT || cmd == CMD_DELETE || cmd == CMD_LOOKUP)
				k = pick_key(cmd != CMD_INSERT);
			else
				k = $urandom();
			send_word(cmd, k);
		end
		wait_for_results();
	endtask

	task automatic test_random_traffic();
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFF_FFFF;
		key_pool[2] = 32'h8000_0000;
		key_pool[3] = 32'h7FFF_FFFF;
		for (int i = 4; i < 8; i++)
			key_pool[i] = $urandom();
		run_random_phase(0, 0);
		run_random_phase(64, 0);
		run_random_phase(0, 64);
		run_random_phase(14, 14);
	endtask

	initial begin
		err_cnt        = 0;
		cycle_cnt      = 0;
		idle_pct       = 0;
		stall_pct      = 0;
		held_count     = 0;
		read_ptr       = 0;
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.command = CMD_INSERT;
		req_ch.key     = '0;
		rsp_ch.ready   = 1'b0;
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_corner_cases();
		test_fill_and_walk();
		test_random_traffic();

		// let the pipe settle, then look for stragglers
		wait_for_results();
		repeat (10)
			@(negedge clk);
		if (pending_results.size() != 0)
			note_error($sformatf("%0d results never arrived", pending_results.size()));
		if (err_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
